[hdl/fgn2d_pkg.sv]
// ----------------------------------------------------------------------------
// fgn2d_pkg
// Shared types, codes and constants of the fractal gradient noise unit.
// ----------------------------------------------------------------------------
package fgn2d_pkg;

	localparam int FRAC_BITS   = 16;
	localparam int PERS_BITS   = 16;
	localparam int TABLE_DEPTH = 256;
	localparam int TIDX_W      = 8;
	localparam int COORD_W     = 24;
	localparam int PROD_W      = 48;
	localparam int GRAD_W      = 20;
	localparam int FADE_W      = 18;
	localparam int LERP_W      = 23;
	localparam int TERM_W      = 34;
	localparam int SUM_W       = 42;

	localparam logic CMD_EVAL = 1'b0;
	localparam logic CMD_LOAD = 1'b1;

	typedef enum logic [2:0] {
		REG_OCTAVES   = 3'd0,
		REG_PERSIST   = 3'd1,
		REG_AMPLITUDE = 3'd2,
		REG_FREQUENCY = 3'd3,
		REG_OFFSET    = 3'd4
	} cfg_reg_t;

	// Corner gradient from the low three bits of a table entry.
	function automatic logic signed [GRAD_W-1:0] grad_pick(
		input logic [2:0]        h,
		input logic signed [17:0] dx,
		input logic signed [17:0] dy
	);
		logic signed [GRAD_W-1:0] a;
		logic signed [GRAD_W-1:0] b;
		logic signed [GRAD_W-1:0] ta;
		logic signed [GRAD_W-1:0] tb;
		a  = h[2] ? GRAD_W'(dy) : GRAD_W'(dx);
		b  = h[2] ? GRAD_W'(dx) : GRAD_W'(dy);
		ta = h[0] ? -a : a;
		tb = h[1] ? -(b <<< 1) : (b <<< 1);
		return ta + tb;
	endfunction

endpackage

[hdl/fractal_gradient_noise_2d_unit.sv]
// ----------------------------------------------------------------------------
// fractal_gradient_noise_2d_unit
// Fractal 2D gradient noise, all octaves evaluated in parallel lanes.
// ----------------------------------------------------------------------------
// channel  dir  fields (low bit up)
// s_*      in   tuser: cmd; tdata: coord_x, coord_y, table_index, table_value
// m_*      out  tdata: noise_value
// cfg_*    in   cfg_idx: register index, cfg_data: value
//
// One request per cycle while s_tready is high; a result leaves from the stage 10 output register.
// Each octave lane holds three copies of the permutation table; a load travels
// down the pipe and writes each copy at the stage that reads it.
// After reset and after a write of persistence or base_amplitude the amplitude
// table is rebuilt entry by entry, with s_tready low.
// A stall on m_tready freezes the whole pipe.
// ----------------------------------------------------------------------------
module fractal_gradient_noise_2d_unit import fgn2d_pkg::*; #(
	parameter int MAX_OCTAVES = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [63:0] s_tdata,   // coord_x, coord_y, table_index, table_value
	input  logic        s_tuser,   // cmd
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // noise_value
	input  logic        cfg_we,
	input  logic [2:0]  cfg_idx,
	input  logic [23:0] cfg_data
);

	localparam int NL = MAX_OCTAVES;
	localparam int NG = (NL + 3) / 4;
	localparam int AW = (NL > 1) ? $clog2(NL) : 1;
	localparam int CW = $clog2(NL + 1);

	// configuration
	logic [3:0]         octaves_q;
	logic [15:0]        persist_q;
	logic [23:0]        base_amp_q;
	logic [23:0]        base_freq_q;
	logic signed [15:0] offset_q;
	logic [CW-1:0]      cnt_q;
	logic [23:0]        amp_q [NL];
	logic               busy;
	logic [39:0]        amp_prod;
	logic [AW-1:0]      amp_wa;
	logic [AW-1:0]      amp_ra;
	logic [4:0]         oct_n;

	assign busy   = cnt_q != '0;
	assign amp_wa = AW'(cnt_q - CW'(1));
	assign amp_ra = AW'(cnt_q - CW'(2));
	assign amp_prod = amp_q[amp_ra] * persist_q;
	assign oct_n  = (32'(octaves_q) > NL) ? 5'(NL) : 5'(octaves_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			octaves_q   <= 4'd4;
			persist_q   <= 16'd32768;
			base_amp_q  <= 24'd65536;
			base_freq_q <= 24'd65536;
			offset_q    <= '0;
			cnt_q       <= CW'(1);
		end else begin
			if (busy) begin
				cnt_q <= (cnt_q == CW'(NL)) ? '0 : cnt_q + CW'(1);
			end
			if (cfg_we) begin
				unique case (cfg_idx)
					REG_OCTAVES:   octaves_q <= cfg_data[3:0];
					REG_PERSIST: begin
						persist_q <= cfg_data[15:0];
						cnt_q     <= CW'(1);
					end
					REG_AMPLITUDE: begin
						base_amp_q <= cfg_data;
						cnt_q      <= CW'(1);
					end
					REG_FREQUENCY: base_freq_q <= cfg_data;
					REG_OFFSET:    offset_q <= cfg_data[15:0];
					default: ;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy) begin
			amp_q[amp_wa] <= (cnt_q == CW'(1)) ? base_amp_q : amp_prod[39:16];
		end
	end

	// pipeline control
	logic en;
	logic acc;
	logic vld_s1, ld_s1, vld_s2, ld_s2;
	logic ev_s3, ev_s4, ev_s5, ev_s6, ev_s7, ev_s8, ev_s9, vld_s10;

	assign en       = !vld_s10 || m_tready;
	assign s_tready = en && !busy;
	assign acc      = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			ld_s1   <= 1'b0;
			vld_s2  <= 1'b0;
			ld_s2   <= 1'b0;
			ev_s3   <= 1'b0;
			ev_s4   <= 1'b0;
			ev_s5   <= 1'b0;
			ev_s6   <= 1'b0;
			ev_s7   <= 1'b0;
			ev_s8   <= 1'b0;
			ev_s9   <= 1'b0;
			vld_s10 <= 1'b0;
		end else if (en) begin
			vld_s1  <= acc;
			ld_s1   <= s_tuser == CMD_LOAD;
			vld_s2  <= vld_s1;
			ld_s2   <= ld_s1;
			ev_s3   <= vld_s2 && !ld_s2;
			ev_s4   <= ev_s3;
			ev_s5   <= ev_s4;
			ev_s6   <= ev_s5;
			ev_s7   <= ev_s6;
			ev_s8   <= ev_s7;
			ev_s9   <= ev_s8;
			vld_s10 <= ev_s9;
		end
	end

	// stage 1: scale coordinates
	logic [PROD_W-1:0] bx_s1, by_s1;
	logic [TIDX_W-1:0] tidx_s1, tval_s1, tidx_s2, tval_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			bx_s1   <= s_tdata[23:0] * base_freq_q;
			by_s1   <= s_tdata[47:24] * base_freq_q;
			tidx_s1 <= s_tdata[55:48];
			tval_s1 <= s_tdata[63:56];
			tidx_s2 <= tidx_s1;
			tval_s2 <= tval_s1;
		end
	end

	logic signed [TERM_W-1:0] term_s7 [NL];

	genvar i;
	generate
		for (i = 0; i < NL; i++) begin : g_lane
			logic [7:0]  mem_a [TABLE_DEPTH];
			logic [7:0]  mem_b [TABLE_DEPTH];
			logic [7:0]  mem_c [TABLE_DEPTH];
			logic [7:0]  cx;
			logic [6:0]  cy;
			logic [15:0] tx1, ty1;
			logic [31:0] sqx, sqy;
			logic [7:0]  ha_s2, hb_s2;
			logic [6:0]  cy_s2;
			logic [15:0] tx_s2, ty_s2, t2x_s2, t2y_s2;
			logic [7:0]  ad1, ad2, ad3, ad4;
			logic [31:0] cbx, cby;
			logic [20:0] qx, qy;
			logic [7:0]  h1_s3, h2_s3, h3_s3, h4_s3;
			logic [15:0] tx_s3, ty_s3, t3x_s3, t3y_s3;
			logic [19:0] qx_s3, qy_s3;
			logic [35:0] ux, uy;
			logic signed [17:0] dx0, dx1, dy0, dy1;
			logic [FADE_W-1:0]  u_s4, v_s4, v_s5;
			logic signed [GRAD_W-1:0] g1_s4, g2_s4, g3_s4, g4_s4;
			logic signed [GRAD_W:0]   d1, d2;
			logic signed [39:0]       p1, p2;
			logic signed [LERP_W-1:0] l1_s5, l2_s5;
			logic signed [LERP_W:0]   d3;
			logic signed [42:0]       p3;
			logic signed [LERP_W-1:0] nz_s6;
			logic signed [48:0]       p4;

			assign cx  = bx_s1[39-i -: 8];
			assign cy  = by_s1[38-i -: 7];
			assign tx1 = bx_s1[31-i -: 16];
			assign ty1 = by_s1[31-i -: 16];
			assign sqx = tx1 * tx1;
			assign sqy = ty1 * ty1;

			// stage 2: corner row lookup, t squared
			always_ff @(posedge clk) begin
				if (en) begin
					if (vld_s1 && ld_s1) begin
						mem_a[tidx_s1] <= tval_s1;
					end
					ha_s2  <= mem_a[cx];
					hb_s2  <= mem_a[cx + 8'd1];
					cy_s2  <= cy;
					tx_s2  <= tx1;
					ty_s2  <= ty1;
					t2x_s2 <= sqx[31:16];
					t2y_s2 <= sqy[31:16];
				end
			end

			assign ad1 = ha_s2 + {1'b0, cy_s2};
			assign ad2 = hb_s2 + {1'b0, cy_s2};
			assign ad3 = ad1 + 8'd1;
			assign ad4 = ad2 + 8'd1;
			assign cbx = t2x_s2 * tx_s2;
			assign cby = t2y_s2 * ty_s2;
			assign qx  = 21'd655360 + 21'(t2x_s2) * 21'd6 - 21'(tx_s2) * 21'd15;
			assign qy  = 21'd655360 + 21'(t2y_s2) * 21'd6 - 21'(ty_s2) * 21'd15;

			// stage 3: corner hashes, t cubed and fade polynomial
			always_ff @(posedge clk) begin
				if (en) begin
					if (vld_s2 && ld_s2) begin
						mem_b[tidx_s2] <= tval_s2;
						mem_c[tidx_s2] <= tval_s2;
					end
					h1_s3  <= mem_b[ad1];
					h2_s3  <= mem_b[ad2];
					h3_s3  <= mem_c[ad3];
					h4_s3  <= mem_c[ad4];
					tx_s3  <= tx_s2;
					ty_s3  <= ty_s2;
					t3x_s3 <= cbx[31:16];
					t3y_s3 <= cby[31:16];
					qx_s3  <= qx[19:0];
					qy_s3  <= qy[19:0];
				end
			end

			assign ux  = t3x_s3 * qx_s3;
			assign uy  = t3y_s3 * qy_s3;
			assign dx0 = $signed({2'b00, tx_s3});
			assign dy0 = $signed({2'b00, ty_s3});
			assign dx1 = dx0 - 18'sd65536;
			assign dy1 = dy0 - 18'sd65536;

			// stage 4: fade weights, corner gradients
			always_ff @(posedge clk) begin
				if (en) begin
					u_s4  <= ux[33:16];
					v_s4  <= uy[33:16];
					g1_s4 <= grad_pick(h1_s3[2:0], dx0, dy0);
					g2_s4 <= grad_pick(h2_s3[2:0], dx1, dy0);
					g3_s4 <= grad_pick(h3_s3[2:0], dx0, dy1);
					g4_s4 <= grad_pick(h4_s3[2:0], dx1, dy1);
				end
			end

			assign d1 = (GRAD_W+1)'(g2_s4) - (GRAD_W+1)'(g1_s4);
			assign d2 = (GRAD_W+1)'(g4_s4) - (GRAD_W+1)'(g3_s4);
			assign p1 = 40'($signed({1'b0, u_s4}) * d1);
			assign p2 = 40'($signed({1'b0, u_s4}) * d2);

			// stage 5: blend along x
			always_ff @(posedge clk) begin
				if (en) begin
					l1_s5 <= LERP_W'(g1_s4) + LERP_W'(p1 >>> FRAC_BITS);
					l2_s5 <= LERP_W'(g3_s4) + LERP_W'(p2 >>> FRAC_BITS);
					v_s5  <= v_s4;
				end
			end

			assign d3 = (LERP_W+1)'(l2_s5) - (LERP_W+1)'(l1_s5);
			assign p3 = 43'($signed({1'b0, v_s5}) * d3);

			// stage 6: blend along y
			always_ff @(posedge clk) begin
				if (en) begin
					nz_s6 <= l1_s5 + LERP_W'(p3 >>> FRAC_BITS);
				end
			end

			assign p4 = 49'(nz_s6 * $signed({1'b0, amp_q[i]}));

			// stage 7: octave weight, idle lanes give zero
			always_ff @(posedge clk) begin
				if (en) begin
					term_s7[i] <= (5'(i) < oct_n) ? TERM_W'(p4 >>> FRAC_BITS) : '0;
				end
			end
		end
	endgenerate

	// stage 8: partial sums of four lanes
	logic signed [SUM_W-1:0] grp_s8 [NG];
	logic signed [SUM_W-1:0] grp_sum [NG];

	always_comb begin
		for (int g = 0; g < NG; g++) begin
			grp_sum[g] = '0;
			for (int k = 0; k < 4; k++) begin
				if (g * 4 + k < NL) begin
					grp_sum[g] = grp_sum[g] + SUM_W'(term_s7[g * 4 + k]);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			grp_s8 <= grp_sum;
		end
	end

	// stage 9: total plus offset
	logic signed [SUM_W-1:0] tot_s9;
	logic signed [SUM_W-1:0] tot;

	always_comb begin
		tot = SUM_W'($signed({offset_q, 16'd0}));
		for (int g = 0; g < NG; g++) begin
			tot = tot + grp_s8[g];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tot_s9 <= tot;
		end
	end

	// stage 10: saturation, output register
	logic [31:0] out_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			if (tot_s9 > SUM_W'(64'sh7FFFFFFF)) begin
				out_s10 <= 32'h7FFFFFFF;
			end else if (tot_s9 < -SUM_W'(64'sh80000000)) begin
				out_s10 <= 32'h80000000;
			end else begin
				out_s10 <= tot_s9[31:0];
			end
		end
	end

	assign m_tvalid = vld_s10;
	assign m_tdata  = out_s10;

`ifndef NO_ASSERTIONS
	a_busy_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !s_tready)
		else $error("request taken while amplitude table rebuilds");

	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !s_tready)
		else $error("request taken while output stalls");

	a_load_enters: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tuser == CMD_LOAD) |=> (vld_s1 && ld_s1))
		else $error("table load lost at pipe entry");

	a_amp_rebuild: assert property (@(posedge clk) disable iff (!arst_n)
		(cfg_we && (cfg_idx == REG_PERSIST || cfg_idx == REG_AMPLITUDE)) |=> busy)
		else $error("amplitude table not rebuilt after write");
`endif

endmodule

[sim/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for fractal_gradient_noise_2d_unit. The permutation
// table is filled first, then a directed table of requests covering offset
// extremes, zero and clamped octave counts, saturation and table reloads is
// run, then random phases under random register settings. Every result is
// checked against a known value or a predictor with its own table and regs.
// ----------------------------------------------------------------------------
module testbench;
	import fgn2d_pkg::*;

	typedef struct {
		logic               cmd;
		logic [23:0]        x;
		logic [23:0]        y;
		logic [7:0]         idx;
		logic [7:0]         val;
		logic [3:0]         oct;
		logic [15:0]        pers;
		logic [23:0]        amp;
		logic [23:0]        freq;
		logic signed [15:0] off;
		bit                 known;
		logic [31:0]        res;
	} stim_row_t;

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [63:0] s_tdata;   // coord_x, coord_y, table_index, table_value
	logic        s_tuser;   // cmd
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;   // noise_value
	logic        cfg_we;
	logic [2:0]  cfg_idx;
	logic [23:0] cfg_data;

	logic [7:0]         perm_copy [0:255];
	logic [3:0]         oct_r;
	logic [15:0]        pers_r;
	logic [23:0]        amp_r;
	logic [23:0]        freq_r;
	logic signed [15:0] off_r;

	logic [31:0] noise_expected [$];
	int          mismatches;
	int          evals_sent;
	int          loads_sent;
	int          results_seen;
	int          cfg_writes;
	int          idle_cycles;
	bit          calm;

	fractal_gradient_noise_2d_unit i_dut (.*);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic longint unsigned fade_curve(longint unsigned t);
		longint unsigned t2, t3, q;
		t2 = (t * t) >> 16;
		t3 = (t2 * t) >> 16;
		q  = 6 * t2 + 10 * 65536 - 15 * t;
		return (t3 * q) >> 16;
	endfunction

	function automatic longint corner_grad(int h, longint dx, longint dy);
		longint a, b;
		a = (h & 4) ? dy : dx;
		b = (h & 4) ? dx : dy;
		return ((h & 1) ? -a : a) + ((h & 2) ? -2 * b : 2 * b);
	endfunction

	function automatic longint lerp_frac(longint p, longint r, longint w);
		return p + ((w * (r - p)) >>> 16);
	endfunction

	function automatic longint octave_sample(longint unsigned px, longint unsigned py);
		int     cx, cy, ha, hb;
		longint tx, ty, u, v;
		cx = int'((px >> 32) & 255);
		cy = int'((py >> 32) & 127);
		tx = longint'((px >> 16) & 16'hFFFF);
		ty = longint'((py >> 16) & 16'hFFFF);
		u  = longint'(fade_curve(tx));
		v  = longint'(fade_curve(ty));
		ha = perm_copy[cx];
		hb = perm_copy[(cx + 1) & 255];
		return lerp_frac(
			lerp_frac(corner_grad(perm_copy[(ha + cy) & 255] & 7, tx, ty),
				corner_grad(perm_copy[(hb + cy) & 255] & 7, tx - 65536, ty), u),
			lerp_frac(corner_grad(perm_copy[(ha + cy + 1) & 255] & 7, tx, ty - 65536),
				corner_grad(perm_copy[(hb + cy + 1) & 255] & 7, tx - 65536, ty - 65536),
				u),
			v);
	endfunction

	function automatic logic [31:0] noise_at(logic [23:0] x, logic [23:0] y);
		longint unsigned bx, by, a;
		longint          total;
		int              n;
		bx    = longint'(x) * longint'(freq_r);
		by    = longint'(y) * longint'(freq_r);
		a     = amp_r;
		total = 0;
		n     = (oct_r > 8) ? 8 : oct_r;
		for (int i = 0; i < n; i++) begin
			total += (octave_sample(bx << i, by << i) * longint'(a)) >>> 16;
			a = (a * pers_r) >> 16;
		end
		total += longint'(off_r) * 65536;
		if (total > 64'sd2147483647) total = 64'sd2147483647;
		if (total < -64'sd2147483648) total = -64'sd2147483648;
		return total[31:0];
	endfunction

	task automatic report(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch: %s got %h expected %h", what, got, want);
		mismatches++;
	endtask

	function automatic int draw_gap();
		return calm ? 0 : $urandom_range(0, 7);
	endfunction

	task automatic drain();
		while (noise_expected.size() != 0) @(negedge clk);
		repeat (30) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [23:0] v);
		cfg_we   <= 1'b1;
		cfg_idx  <= r;
		cfg_data <= v;
		@(negedge clk);
		cfg_writes++;
		case (r)
			REG_OCTAVES:   oct_r  = v[3:0];
			REG_PERSIST:   pers_r = v[15:0];
			REG_AMPLITUDE: amp_r  = v;
			REG_FREQUENCY: freq_r = v;
			REG_OFFSET:    off_r  = v[15:0];
			default: ;
		endcase
	endtask

	task automatic set_regs(logic [3:0] o, logic [15:0] p, logic [23:0] a,
			logic [23:0] f, logic signed [15:0] d);
		if (o == oct_r && p == pers_r && a == amp_r && f == freq_r && d == off_r)
			return;
		s_tvalid <= 1'b0;
		drain();
		if (o != oct_r) write_reg(REG_OCTAVES, 24'(o));
		if (p != pers_r) write_reg(REG_PERSIST, 24'(p));
		if (a != amp_r) write_reg(REG_AMPLITUDE, a);
		if (f != freq_r) write_reg(REG_FREQUENCY, f);
		if (d != off_r) write_reg(REG_OFFSET, 24'(d[15:0]));
		cfg_we <= 1'b0;
	endtask

	// one request; the signal stays high into the next call when its gap is zero
	task automatic send_req(logic cmd, logic [23:0] x, logic [23:0] y,
			logic [7:0] idx, logic [7:0] val, bit known, logic [31:0] res);
		int gap;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= cmd;
		s_tdata  <= {val, idx, y, x};
		do @(posedge clk); while (!s_tready);
		if (cmd == CMD_LOAD) begin
			perm_copy[idx] = val;
			loads_sent++;
		end else begin
			noise_expected.push_back(known ? res : noise_at(x, y));
			evals_sent++;
		end
		@(negedge clk);
	endtask

	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			results_seen++;
			if (noise_expected.size() == 0)
				report("unexpected result", m_tdata, 32'h0);
			else begin
				logic [31:0] want;
				want = noise_expected.pop_front();
				if (m_tdata !== want) report("noise_value", m_tdata, want);
			end
		end
	end

	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			int gap;
			@(negedge clk);
			gap = draw_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > 5000) begin
			$display("timeout: no traffic");
			$display("CHECKS FAILED");
			$finish;
		end
	end

	initial begin
		stim_row_t rows [];
		logic [7:0] shuffle [0:255];
		s_tvalid    = 1'b0;
		s_tuser     = 1'b0;
		s_tdata     = '0;
		cfg_we      = 1'b0;
		cfg_idx     = '0;
		cfg_data    = '0;
		arst_n      = 1'b0;
		idle_cycles = 0;
		mismatches  = 0;
		calm        = 1'b0;
		oct_r       = 4'd4;
		pers_r      = 16'd32768;
		amp_r       = 24'd65536;
		freq_r      = 24'd65536;
		off_r       = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		for (int i = 0; i < 256; i++) shuffle[i] = i[7:0];
		for (int i = 255; i > 0; i--) begin
			int j;
			logic [7:0] t;
			j = $urandom_range(0, i);
			t = shuffle[i];
			shuffle[i] = shuffle[j];
			shuffle[j] = t;
		end
		for (int i = 0; i < 256; i++)
			send_req(CMD_LOAD, '0, '0, i[7:0], shuffle[i], 0, '0);

		rows = '{
			'{CMD_EVAL, 24'h0, 24'h0, 8'h0, 8'h0, 4, 16'd32768, 24'd65536, 24'd65536,
				16'sd0, 1, 32'h0},
			'{CMD_EVAL, 24'hFFFFFF, 24'hFFFFFF, 8'h0, 8'h0, 4, 16'd32768, 24'd65536,
				24'd65536, 16'sd0, 0, 32'h0},
			'{CMD_EVAL, 24'h018000, 24'h008000, 8'h0, 8'h0, 4, 16'd32768, 24'd65536,
				24'd65536, 16'sd0, 0, 32'h0},
			'{CMD_EVAL, 24'h123456, 24'hABCDEF, 8'h0, 8'h0, 0, 16'd32768, 24'd65536,
				24'd65536, 16'sd32767, 1, 32'h7FFF0000},
			'{CMD_EVAL, 24'hFFFFFF, 24'h000000, 8'h0, 8'h0, 0, 16'd32768, 24'd65536,
				24'd65536, -16'sd32768, 1, 32'h80000000},
			'{CMD_EVAL, 24'h5A5A5A, 24'hA5A5A5, 8'h0, 8'h0, 8, 16'd0, 24'd0, 24'd0,
				-16'sd1, 1, 32'hFFFF0000},
			'{CMD_EVAL, 24'h7FC001, 24'h3FFFFF, 8'h0, 8'h0, 15, 16'd65535, 24'hFFFFFF,
				24'hFFFFFF, 16'sd32767, 0, 32'h0},
			'{CMD_EVAL, 24'h00FFFF, 24'hFF0000, 8'h0, 8'h0, 15, 16'd65535, 24'hFFFFFF,
				24'hFFFFFF, 16'sd32767, 0, 32'h0},
			'{CMD_EVAL, 24'h7FC001, 24'h3FFFFF, 8'h0, 8'h0, 15, 16'd65535, 24'hFFFFFF,
				24'hFFFFFF, -16'sd32768, 0, 32'h0},
			'{CMD_EVAL, 24'h00FFFF, 24'hFF0000, 8'h0, 8'h0, 9, 16'd65535, 24'hFFFFFF,
				24'hFFFFFF, -16'sd32768, 0, 32'h0},
			'{CMD_EVAL, 24'hC0FFEE, 24'h00BEEF, 8'h0, 8'h0, 1, 16'd40000, 24'h800000,
				24'h000100, 16'sd5, 0, 32'h0},
			'{CMD_LOAD, 24'h0, 24'h0, 8'h00, 8'hFF, 1, 16'd40000, 24'h800000,
				24'h000100, 16'sd5, 0, 32'h0},
			'{CMD_LOAD, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 8'h00, 1, 16'd40000, 24'h800000,
				24'h000100, 16'sd5, 0, 32'h0},
			'{CMD_EVAL, 24'hFF8000, 24'h7F8000, 8'h0, 8'h0, 2, 16'd40000, 24'h010000,
				24'h010000, 16'sd0, 0, 32'h0},
			'{CMD_EVAL, 24'h000001, 24'h000001, 8'h0, 8'h0, 2, 16'd40000, 24'h010000,
				24'h010000, 16'sd0, 0, 32'h0},
			'{CMD_EVAL, 24'h7FFFFF, 24'h800000, 8'h0, 8'h0, 8, 16'd32768, 24'h010000,
				24'h020000, 16'sd0, 0, 32'h0}
		};
		foreach (rows[k]) begin
			set_regs(rows[k].oct, rows[k].pers, rows[k].amp, rows[k].freq, rows[k].off);
			send_req(rows[k].cmd, rows[k].x, rows[k].y, rows[k].idx, rows[k].val,
				rows[k].known, rows[k].res);
		end

		for (int ph = 0; ph < 7; ph++) begin
			logic [3:0]  o;
			logic [15:0] p;
			logic [23:0] a, f;
			o = (ph == 0) ? 4'd15 : 4'($urandom_range(0, 15));
			p = (ph == 1) ? 16'hFFFF : 16'($urandom);
			a = (ph == 2) ? 24'hFFFFFF : 24'($urandom);
			f = (ph == 3) ? 24'hFFFFFF : ($urandom_range(0, 1) ? 24'($urandom) :
				24'($urandom_range(0, 24'h03FFFF)));
			calm = (ph == 4);
			set_regs(o, p, a, f, 16'($urandom));
			for (int n = 0; n < 62; n++) begin
				if ($urandom_range(0, 99) < 12)
					send_req(CMD_LOAD, 24'($urandom), 24'($urandom), 8'($urandom),
						8'($urandom), 0, '0);
				else
					send_req(CMD_EVAL, 24'($urandom), 24'($urandom), 8'($urandom),
						8'($urandom), 0, '0);
			end
		end
		s_tvalid <= 1'b0;
		calm = 1'b0;
		drain();

		$display("covered %0d evaluations, %0d table loads, %0d register writes",
			evals_sent, loads_sent, cfg_writes);
		$display("%0d results checked, %0d mismatches", results_seen, mismatches);
		if (mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

[sim.f]
hdl/fgn2d_pkg.sv
hdl/fractal_gradient_noise_2d_unit.sv
sim/testbench.sv
